// File: hw/rtl/mm3_pkg.sv
// mm3_pkg: shared types, constants and helper functions for the MurmurHash3
// x86 128-bit hash block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mm3_pkg;

	typedef logic [31:0] word_t;

	localparam word_t SEED_RST = 32'hfd14deff;

	// block/tail scramble constants
	localparam word_t MC1 = 32'h239b961b;
	localparam word_t MC2 = 32'hab0e9789;
	localparam word_t MC3 = 32'h38b34ae5;
	localparam word_t MC4 = 32'ha1e38b93;

	// fmix constants
	localparam word_t FM1 = 32'h85ebca6b;
	localparam word_t FM2 = 32'hc2b2ae35;

	localparam word_t MUL_ZERO = 32'd0;
	localparam word_t MUL_ONE  = 32'd1;
	localparam word_t MUL_FIVE = 32'd5;

	// per-lane tables, indexed by lane number
	localparam word_t CA_TBL [4] = '{MC1, MC2, MC3, MC4};
	localparam word_t CB_TBL [4] = '{MC2, MC3, MC4, MC1};
	localparam word_t KC_TBL [4] = '{32'h561ccd1b, 32'h0bcaa747, 32'h96cd1c35, 32'h32ac3b17};
	localparam logic [4:0] RA_TBL [4] = '{5'd15, 5'd16, 5'd17, 5'd18};
	localparam logic [4:0] RB_TBL [4] = '{5'd19, 5'd17, 5'd15, 5'd13};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BLOCK,
		ST_TAIL,
		ST_SUM,
		ST_FMIX,
		ST_OUTADD,
		ST_DONE
	} state_t;

	// multiplicand source of the multiply-add unit
	typedef enum logic [2:0] {
		A_WORD,
		A_ACC_ROT,
		A_MIX,
		A_TAIL,
		A_LANE,
		A_ACC,
		A_XS16,
		A_XS13
	} asel_t;

	// addend source
	typedef enum logic [2:0] {
		C_ZERO,
		C_R1,
		C_R2,
		C_R3,
		C_KONST,
		C_SUM
	} csel_t;

	// value shifted into the lane ring
	typedef enum logic {
		R_ACC,
		R_XS16
	} rsel_t;

	typedef struct packed {
		logic       busy;
		logic       mac_en;
		asel_t      a_sel;
		word_t      b;
		csel_t      c_sel;
		word_t      kc;
		logic [4:0] rot;
		logic [1:0] lane;
		logic       masked;
		logic       ring_rot;
		rsel_t      ring_in;
		logic       sum_ld;
		logic       out_ld;
	} ctl_t;

	function automatic word_t rotl(input word_t x, input logic [4:0] r);
		logic [63:0] t;
		t = {x, x} << r;
		return t[63:32];
	endfunction

	function automatic word_t xs16(input word_t x);
		return x ^ (x >> 16);
	endfunction

	function automatic word_t xs13(input word_t x);
		return x ^ (x >> 13);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mm3_mac.sv
// mm3_mac: shared 32-bit multiply-add unit with registered result.
// Depends on mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm3_mac
	import mm3_pkg::*;
(
	input  wire   clk,
	input  wire   en,
	input  word_t a,
	input  word_t b,
	input  word_t c,
	output word_t acc
);

	// low word of the product only; everything is modulo 2^32
	word_t prod;
	word_t acc_q;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= prod + c;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// File: hw/rtl/mm3_seq.sv
// mm3_seq: step sequencer that drives the shared multiply-add unit and the
// lane ring through block mix, tail, cross-add, fmix and output. Uses mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm3_seq
	import mm3_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  blk_go,
	input  wire  fin_go,
	input  wire  out_free,
	output ctl_t ctl
);

	state_t     state_q, state_d;
	logic [1:0] lane_q, lane_d;
	logic [2:0] ph_q, ph_d;
	logic       fin_q, fin_d;
	logic       pass_q, pass_d;
	word_t      lane_gate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q  <= 2'd0;
			ph_q    <= 3'd0;
			fin_q   <= 1'b0;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			lane_q  <= lane_d;
			ph_q    <= ph_d;
			fin_q   <= fin_d;
			pass_q  <= pass_d;
		end
	end

	// lane 0 takes the sum alone, the others add it
	assign lane_gate = (lane_q == 2'd0) ? MUL_ZERO : MUL_ONE;

	always_comb begin
		state_d = state_q;
		lane_d  = lane_q;
		ph_d    = ph_q + 3'd1;
		fin_d   = fin_q;
		pass_d  = pass_q;

		ctl        = '0;
		ctl.busy   = (state_q != ST_IDLE);
		ctl.lane   = lane_q;
		ctl.masked = (state_q == ST_TAIL);
		ctl.a_sel  = A_ACC;
		ctl.c_sel  = C_ZERO;
		ctl.ring_in = R_ACC;
		ctl.b      = MUL_ONE;

		case (state_q)
			ST_IDLE: begin
				ph_d   = 3'd0;
				lane_d = 2'd0;
				if (blk_go) begin
					state_d = ST_BLOCK;
					fin_d   = fin_go;
				end else if (fin_go) begin
					state_d = ST_TAIL;
				end
			end

			ST_BLOCK, ST_TAIL: begin
				case (ph_q)
					3'd0: begin
						ctl.mac_en = 1'b1;
						ctl.a_sel  = A_WORD;
						ctl.b      = CA_TBL[lane_q];
					end
					3'd1: begin
						ctl.mac_en = 1'b1;
						ctl.a_sel  = A_ACC_ROT;
						ctl.rot    = RA_TBL[lane_q];
						ctl.b      = CB_TBL[lane_q];
					end
					3'd2: begin
						ctl.mac_en = 1'b1;
						if (state_q == ST_BLOCK) begin
							ctl.a_sel = A_MIX;
							ctl.rot   = RB_TBL[lane_q];
							ctl.c_sel = C_R1;
						end else begin
							ctl.a_sel = A_TAIL;
						end
					end
					3'd3: begin
						if (state_q == ST_BLOCK) begin
							ctl.mac_en = 1'b1;
							ctl.b      = MUL_FIVE;
							ctl.c_sel  = C_KONST;
							ctl.kc     = KC_TBL[lane_q];
						end
					end
					default: ;
				endcase
				// last step of a lane: shift the new value into the ring
				if ((state_q == ST_BLOCK && ph_q == 3'd4) ||
				    (state_q == ST_TAIL && ph_q == 3'd3)) begin
					ctl.ring_rot = 1'b1;
					ph_d         = 3'd0;
					lane_d       = lane_q + 2'd1;
					if (lane_q == 2'd3) begin
						if (state_q == ST_TAIL) begin
							state_d = ST_SUM;
						end else if (fin_q) begin
							state_d = ST_TAIL;
							fin_d   = 1'b0;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end

			ST_SUM: begin
				case (ph_q)
					3'd0: begin
						ctl.mac_en = 1'b1;
						ctl.a_sel  = A_LANE;
						ctl.c_sel  = C_R1;
					end
					3'd1: begin
						ctl.mac_en = 1'b1;
						ctl.c_sel  = C_R2;
					end
					3'd2: begin
						ctl.mac_en = 1'b1;
						ctl.c_sel  = C_R3;
					end
					default: begin
						ctl.sum_ld = 1'b1;
						ph_d       = 3'd0;
						state_d    = pass_q ? ST_OUTADD : ST_FMIX;
					end
				endcase
			end

			ST_FMIX: begin
				case (ph_q)
					3'd0: begin
						ctl.mac_en = 1'b1;
						ctl.a_sel  = A_LANE;
						ctl.b      = lane_gate;
						ctl.c_sel  = C_SUM;
					end
					3'd1: begin
						ctl.mac_en = 1'b1;
						ctl.a_sel  = A_XS16;
						ctl.b      = FM1;
					end
					3'd2: begin
						ctl.mac_en = 1'b1;
						ctl.a_sel  = A_XS13;
						ctl.b      = FM2;
					end
					default: begin
						ctl.ring_rot = 1'b1;
						ctl.ring_in  = R_XS16;
						ph_d         = 3'd0;
						lane_d       = lane_q + 2'd1;
						if (lane_q == 2'd3) begin
							state_d = ST_SUM;
							pass_d  = 1'b1;
						end
					end
				endcase
			end

			ST_OUTADD: begin
				if (ph_q == 3'd0) begin
					ctl.mac_en = 1'b1;
					ctl.a_sel  = A_LANE;
					ctl.b      = lane_gate;
					ctl.c_sel  = C_SUM;
				end else begin
					ctl.ring_rot = 1'b1;
					ph_d         = 3'd0;
					lane_d       = lane_q + 2'd1;
					if (lane_q == 2'd3) begin
						state_d = ST_DONE;
					end
				end
			end

			ST_DONE: begin
				ph_d = 3'd0;
				if (out_free) begin
					ctl.out_ld = 1'b1;
					pass_d     = 1'b0;
					state_d    = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/murmur3_x86_128_hash.sv
// murmur3_x86_128_hash: byte-stream MurmurHash3 x86 128-bit hasher, top level.
// Depends on mm3_pkg, mm3_mac and mm3_seq.
// Bytes transfer at one per cycle while input is not stalled; the 16th byte of
// a block stalls input for four lanes of five steps on the one multiply-add
// unit. A last item stalls input until its result reaches the output register
// (after the block mix if it also closes a block); the block then takes input
// again while the result waits in the output register.
// Reset (arst_n low, asynchronous) clears control state and sets the seed.
`timescale 1ns / 1ps
`default_nettype none

module murmur3_x86_128_hash
	import mm3_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	// seed register
	input  wire         cfg_we,
	input  wire  [31:0] cfg_wdata,
	// byte input
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	input  wire         has_byte,
	input  wire         last,
	// hash output
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] lane1,
	output logic [31:0] lane2,
	output logic [31:0] lane3,
	output logic [31:0] lane4
);

	ctl_t       ctl;
	word_t      acc;
	word_t      mac_a;
	word_t      mac_c;

	word_t      seed_q;
	word_t      cnt_q;
	logic       in_msg_q;
	logic [7:0] buf_q [16];
	word_t      ring_q [4];
	word_t      sum_q;
	word_t      out_q [4];
	logic       out_valid_q;

	logic       xfer_in;
	logic       seed_ld;
	logic       blk_go;
	logic       fin_go;
	logic       out_free;
	logic       tail_need;
	word_t      blk_word [4];
	word_t      word_sel;

	// input transfer and sequence triggers
	assign in_stall = ctl.busy;
	assign xfer_in  = in_valid && !in_stall;
	assign seed_ld  = xfer_in && (has_byte || last) && !in_msg_q;
	// byte that fills the 16-byte block
	assign blk_go   = xfer_in && has_byte && (cnt_q[3:0] == 4'hf);
	assign fin_go   = xfer_in && last;
	assign out_free = !out_valid_q || !out_stall;

	mm3_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.blk_go   (blk_go),
		.fin_go   (fin_go),
		.out_free (out_free),
		.ctl      (ctl)
	);

	// Little-endian words of the block. In the tail only bytes below the
	// fill level count; stale bytes of an earlier block read as zero.
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			blk_word[j] = '0;
			for (int k = 0; k < 4; k++) begin
				if (!ctl.masked || (4'(j * 4 + k) < cnt_q[3:0])) begin
					blk_word[j][8 * k +: 8] = buf_q[j * 4 + k];
				end
			end
		end
	end

	assign word_sel  = blk_word[ctl.lane];
	// a tail word exists for lane j when more than 4*j bytes are left
	assign tail_need = (cnt_q[3:0] > {ctl.lane, 2'b00});

	// operand selection for the shared unit
	always_comb begin
		case (ctl.a_sel)
			A_WORD:    mac_a = word_sel;
			A_ACC_ROT: mac_a = rotl(acc, ctl.rot);
			A_MIX:     mac_a = rotl(ring_q[0] ^ acc, ctl.rot);
			// tail scramble and the length fold in one step
			A_TAIL:    mac_a = ring_q[0] ^ cnt_q ^ (tail_need ? acc : '0);
			A_LANE:    mac_a = ring_q[0];
			A_ACC:     mac_a = acc;
			A_XS16:    mac_a = xs16(acc);
			A_XS13:    mac_a = xs13(acc);
			default:   mac_a = acc;
		endcase
	end

	always_comb begin
		case (ctl.c_sel)
			C_ZERO:  mac_c = '0;
			C_R1:    mac_c = ring_q[1];
			C_R2:    mac_c = ring_q[2];
			C_R3:    mac_c = ring_q[3];
			C_KONST: mac_c = ctl.kc;
			C_SUM:   mac_c = sum_q;
			default: mac_c = '0;
		endcase
	end

	mm3_mac u_mac (
		.clk (clk),
		.en  (ctl.mac_en),
		.a   (mac_a),
		.b   (ctl.b),
		.c   (mac_c),
		.acc (acc)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= SEED_RST;
			cnt_q       <= '0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (ctl.out_ld) begin
				cnt_q    <= '0;
				in_msg_q <= 1'b0;
			end else begin
				if (xfer_in && has_byte) begin
					cnt_q <= cnt_q + 32'd1;
				end
				if (seed_ld) begin
					in_msg_q <= 1'b1;
				end
			end
			if (ctl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// block buffer
	always_ff @(posedge clk) begin
		if (xfer_in && has_byte) begin
			buf_q[cnt_q[3:0]] <= data_byte;
		end
	end

	// Lane ring: position 0 is the lane being worked on. Each lane's result
	// enters at position 3, so after four lanes the order is restored and
	// position 1 always holds the next lane (already updated for lane 3).
	always_ff @(posedge clk) begin
		if (seed_ld) begin
			for (int i = 0; i < 4; i++) begin
				ring_q[i] <= seed_q;
			end
		end else if (ctl.ring_rot) begin
			ring_q[0] <= ring_q[1];
			ring_q[1] <= ring_q[2];
			ring_q[2] <= ring_q[3];
			ring_q[3] <= (ctl.ring_in == R_XS16) ? xs16(acc) : acc;
		end
	end

	// cross-add sum (final lane 1)
	always_ff @(posedge clk) begin
		if (ctl.sum_ld) begin
			sum_q <= acc;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			for (int i = 0; i < 4; i++) begin
				out_q[i] <= ring_q[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign lane1     = out_q[0];
	assign lane2     = out_q[1];
	assign lane3     = out_q[2];
	assign lane4     = out_q[3];

endmodule

`default_nettype wire

// File: hw/rtl/mm3_checker.sv
// mm3_checker: port-level assertions for murmur3_x86_128_hash, bound to the
// top level. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module mm3_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        last,
	input wire        out_valid,
	input wire        out_stall,
	input wire [31:0] lane1,
	input wire [31:0] lane2,
	input wire [31:0] lane3,
	input wire [31:0] lane4
);

	logic [1:0] pend_q;
	logic       fin_xfer;
	logic       out_xfer;

	assign fin_xfer = in_valid && !in_stall && last;
	assign out_xfer = out_valid && !out_stall;

	// messages ended but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (fin_xfer && !out_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_xfer && !fin_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(lane1) && $stable(lane2)
			&& $stable(lane3) && $stable(lane4))
		else $error("stalled result changed");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fin_xfer |=> in_stall)
		else $error("input not stalled while finishing a message");

	a_out_has_msg: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != 2'd0)
		else $error("result without a finished message");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many finished messages outstanding");

endmodule

bind murmur3_x86_128_hash mm3_checker u_chk (.*);

`default_nettype wire
